// ----- src/acws_pkg.sv -----
// Package for auto_contrast_window_stretch: beat payload types, register indexes
// and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package acws_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned DivCntW = 3;

  localparam logic [PixW-1:0] PixMin = '0;
  localparam logic [PixW-1:0] PixMax = '1;

  localparam logic [CfgIdxW-1:0] CFG_MANUAL_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MANUAL_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_ENABLE = 2'd2;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            in_region;
    logic            frame_end;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] intensity;
    logic [PixW-1:0] current_low;
    logic [PixW-1:0] current_high;
  } out_t;

  typedef struct packed {
    logic run;
    logic wr_sat;
    logic wr_quo;
    logic div_load;
    logic div_step;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic rebuild_req;
    logic sat;
    logic div_last;
    logic idx_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/acws_ctrl.sv -----
// Controller for auto_contrast_window_stretch: sequences the ramp table rebuild
// and gates pixel traffic. Depends on acws_pkg.
`default_nettype none

module acws_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire acws_pkg::sts_t sts_i,
  output acws_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_RUN,
    S_LOAD,
    S_DIV,
    S_WRITE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.rebuild_req) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.sat) begin
          cmd_o.wr_sat  = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_last) begin
            state_d = S_RUN;
          end
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_quo  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = sts_i.idx_last ? S_RUN : S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // rebuild the table from the reset window before the first beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/acws_dp.sv -----
// Datapath for auto_contrast_window_stretch: registers, region statistics,
// ramp table memory, bit-serial divider and output register. Depends on acws_pkg.
`default_nettype none

module acws_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire acws_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output acws_pkg::out_t                         out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [acws_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [acws_pkg::CfgW-1:0]         cfg_data_i,
  input  wire acws_pkg::cmd_t                    cmd_i,
  output acws_pkg::sts_t                         sts_o
);

  localparam int unsigned PW = acws_pkg::PixW;

  logic [PW-1:0] man_low_q, man_high_q;
  logic          auto_q;
  logic [PW-1:0] win_low_q, win_high_q;
  logic [PW-1:0] min_q, max_q;
  logic          seen_q;

  logic [PW-1:0] idx_q;
  logic [PW-1:0] rem_q, quo_q;
  logic [acws_pkg::DivCntW-1:0] cnt_q;

  logic [PW-1:0] ram [2**PW];
  logic [PW-1:0] rd_q, cur_low_q, cur_high_q;
  logic          out_valid_q;

  logic          accept, cfg_we, hit, seen_n, auto_upd;
  logic [PW-1:0] min_n, max_n;
  logic          cfg_load;
  logic [PW-1:0] cfg_low, cfg_high;
  logic [PW-1:0] den, xoff, sat_val, wr_data;
  logic [2*PW-1:0] num;
  logic [PW:0]   trial;
  logic          trial_ge;
  logic          wr_en;

  assign in_stall_o  = !cmd_i.run || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = cmd_i.run;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // region statistics including the current beat
  assign hit    = in_data_i.in_region && (in_data_i.pixel != acws_pkg::PixMin) &&
                  (in_data_i.pixel != acws_pkg::PixMax);
  assign min_n  = (hit && (in_data_i.pixel < min_q)) ? in_data_i.pixel : min_q;
  assign max_n  = (hit && (in_data_i.pixel > max_q)) ? in_data_i.pixel : max_q;
  assign seen_n = seen_q || in_data_i.in_region;
  assign auto_upd = accept && in_data_i.frame_end && auto_q && seen_n;

  always_comb begin
    cfg_load = 1'b0;
    cfg_low  = man_low_q;
    cfg_high = man_high_q;
    case (cfg_index_i)
      acws_pkg::CFG_MANUAL_LOW: begin
        cfg_load = !auto_q;
        cfg_low  = cfg_data_i;
      end
      acws_pkg::CFG_MANUAL_HIGH: begin
        cfg_load = !auto_q;
        cfg_high = cfg_data_i;
      end
      acws_pkg::CFG_AUTO_ENABLE: begin
        cfg_load = !cfg_data_i[0];
      end
      default: begin
        cfg_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      man_low_q  <= acws_pkg::PixMin;
      man_high_q <= acws_pkg::PixMax;
      auto_q     <= 1'b1;
      win_low_q  <= acws_pkg::PixMin;
      win_high_q <= acws_pkg::PixMax;
      min_q      <= acws_pkg::PixMax;
      max_q      <= acws_pkg::PixMin;
      seen_q     <= 1'b0;
    end else begin
      if (accept) begin
        if (in_data_i.frame_end) begin
          min_q  <= acws_pkg::PixMax;
          max_q  <= acws_pkg::PixMin;
          seen_q <= 1'b0;
        end else begin
          min_q  <= min_n;
          max_q  <= max_n;
          seen_q <= seen_n;
        end
      end
      if (cfg_we) begin
        case (cfg_index_i)
          acws_pkg::CFG_MANUAL_LOW:  man_low_q  <= cfg_data_i;
          acws_pkg::CFG_MANUAL_HIGH: man_high_q <= cfg_data_i;
          acws_pkg::CFG_AUTO_ENABLE: auto_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cfg_we && cfg_load) begin
        win_low_q  <= cfg_low;
        win_high_q <= cfg_high;
      end else if (auto_upd) begin
        win_low_q  <= (min_n == acws_pkg::PixMax) ? acws_pkg::PixMin : min_n;
        win_high_q <= (max_n == acws_pkg::PixMin) ? acws_pkg::PixMax : max_n;
      end
    end
  end

  // ramp entry: saturate outside the window, else 255*(idx-low)/(high-low)
  assign den     = win_high_q - win_low_q;
  assign xoff    = idx_q - win_low_q;
  assign num     = {xoff, {PW{1'b0}}} - {{PW{1'b0}}, xoff};
  assign sat_val = (idx_q >= win_high_q) ? acws_pkg::PixMax : acws_pkg::PixMin;
  assign trial   = {rem_q, quo_q[PW-1]};
  assign trial_ge = trial >= {1'b0, den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.div_load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= num[2*PW-1:PW];
      quo_q <= num[PW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial[PW-1:0] - den : trial[PW-1:0];
      quo_q <= {quo_q[PW-2:0], trial_ge};
    end
  end

  assign wr_en   = cmd_i.wr_sat || cmd_i.wr_quo;
  assign wr_data = cmd_i.wr_sat ? sat_val : quo_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ram[idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q       <= ram[in_data_i.pixel];
      cur_low_q  <= win_low_q;
      cur_high_q <= win_high_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.intensity    = rd_q;
  assign out_data_o.current_low  = cur_low_q;
  assign out_data_o.current_high = cur_high_q;

  assign sts_o.rebuild_req = auto_upd || (cfg_we && cfg_load);
  assign sts_o.sat         = (idx_q >= win_high_q) || (idx_q < win_low_q);
  assign sts_o.div_last    = (cnt_q == {acws_pkg::DivCntW{1'b1}});
  assign sts_o.idx_last    = (idx_q == acws_pkg::PixMax);

endmodule

`default_nettype wire

// ----- src/auto_contrast_window_stretch.sv -----
// The result beat is registered and appears in the cycle after its pixel
// beat is accepted. One pixel per cycle unless held off by a rebuild or an
// output stall, read from the 256-entry ramp table memory. A window change
// (frame end in auto mode, manual load) rebuilds the table with input and
// configuration held off; saturated entries skip the 8-step serial divider.
// After reset the same pass builds the identity ramp before the first beat.
`default_nettype none

module auto_contrast_window_stretch (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire acws_pkg::in_t                in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output acws_pkg::out_t                    out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [acws_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [acws_pkg::CfgW-1:0]    cfg_data_i
);

  acws_pkg::cmd_t cmd;
  acws_pkg::sts_t sts;

  acws_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  acws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
